// File: rtl/bsd_pkg.sv
// ----------------------------------------------------------------------------
// bsd_pkg: shared types and constants of the box signed distance block
// Fixed widths of the squared-distance path and the root cell word.
// ----------------------------------------------------------------------------
package bsd_pkg;

	localparam int CFG_W     = 23;          // register width
	localparam int CFG_IDX_W = 2;           // register index width
	localparam int OUT_W     = 26;          // signed_distance width
	localparam int U_W       = 27;          // clamped positive offset
	localparam int SQ_W      = 2 * U_W;     // one square
	localparam int SUM_W     = 2 * U_W;     // sum of three squares, fits
	localparam int ROOT_W    = SUM_W / 2;   // root bits, one per cell
	localparam int REM_W     = ROOT_W + 2;  // working remainder

	localparam int D_CLAMP = 67108864;      // clamp of a positive offset
	localparam logic [OUT_W-1:0] OUT_MAX = {1'b0, {(OUT_W-1){1'b1}}};

	localparam logic [CFG_IDX_W-1:0] REG_SCENE_X = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_SCENE_Y = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_SCENE_Z = 2'd2;
	localparam logic [CFG_IDX_W-1:0] REG_CUBE    = 2'd3;

	// word handed from one root cell to the next
	typedef struct packed {
		logic [SUM_W-1:0]  rad;     // radicand bits still to consume, msb first
		logic [REM_W-1:0]  rem;     // partial remainder
		logic [ROOT_W-1:0] root;    // partial root
		logic              in_box;  // point lies inside the cube
		logic [OUT_W-1:0]  half;    // floor(max offset / 2), used when inside
	} sqrt_word_t;

endpackage

// File: rtl/bsd_front.sv
// ----------------------------------------------------------------------------
// bsd_front: axis offsets, clamp, squares and sum
// Five stages with per-stage valid; bubbles collapse as the chain stalls.
// ----------------------------------------------------------------------------
module bsd_front #(
	parameter int COORD_WIDTH = 24
) (
	input  logic                                    clk,
	input  logic                                    arst_n,
	input  logic                                    in_valid,
	output logic                                    in_ready,
	input  logic signed [COORD_WIDTH-1:0]           point_x,
	input  logic signed [COORD_WIDTH-1:0]           point_y,
	input  logic signed [COORD_WIDTH-1:0]           point_z,
	input  logic [2:0][bsd_pkg::CFG_W-1:0]          scene,
	input  logic [bsd_pkg::CFG_W-1:0]               cube,
	output logic                                    out_valid,
	input  logic                                    out_ready,
	output bsd_pkg::sqrt_word_t                     out_word
);

	// 2*p - scene, then |.| - cube, then room to compare against the clamp
	localparam int TW = ((COORD_WIDTH + 1 > bsd_pkg::CFG_W + 1) ?
		COORD_WIDTH + 1 : bsd_pkg::CFG_W + 1) + 1;
	localparam int DW = TW + 1;
	localparam int XW = (DW > bsd_pkg::U_W + 1) ? DW : bsd_pkg::U_W + 1;

	logic signed [COORD_WIDTH-1:0] pnt [3];

	logic v_s1, v_s2, v_s3, v_s4, v_s5;
	logic rdy1, rdy2, rdy3, rdy4, rdy5;

	logic signed [TW-1:0]          t_s1   [3];
	logic signed [DW-1:0]          d_s2   [3];
	logic [bsd_pkg::U_W-1:0]       u_s3   [3];
	logic [bsd_pkg::SQ_W-1:0]      sq_s4  [3];
	logic [bsd_pkg::SUM_W-1:0]     sum_s5;
	logic                          inside_s3, inside_s4, inside_s5;
	logic [bsd_pkg::OUT_W-1:0]     half_s3, half_s4, half_s5;

	logic signed [TW-1:0] t_nx  [3];
	logic signed [DW-1:0] d_nx  [3];
	logic [bsd_pkg::U_W-1:0] u_nx [3];
	logic signed [XW-1:0] dx    [3];
	logic signed [XW-1:0] mx;
	logic signed [XW-1:0] mx_half;

	assign pnt[0] = point_x;
	assign pnt[1] = point_y;
	assign pnt[2] = point_z;

	assign rdy5     = !v_s5 || out_ready;
	assign rdy4     = !v_s4 || rdy5;
	assign rdy3     = !v_s3 || rdy4;
	assign rdy2     = !v_s2 || rdy3;
	assign rdy1     = !v_s1 || rdy2;
	assign in_ready = rdy1;

	always_comb begin
		for (int a = 0; a < 3; a++) begin
			t_nx[a] = (TW'(pnt[a]) <<< 1) - $signed(TW'(scene[a]));
			d_nx[a] = ((t_s1[a] < 0) ? -DW'(t_s1[a]) : DW'(t_s1[a]))
				- $signed(DW'(cube));
			dx[a]   = XW'(d_s2[a]);
			if (dx[a] <= 0) begin
				u_nx[a] = '0;
			end else if (dx[a] > $signed(XW'(bsd_pkg::D_CLAMP))) begin
				u_nx[a] = bsd_pkg::U_W'(bsd_pkg::D_CLAMP);
			end else begin
				u_nx[a] = dx[a][bsd_pkg::U_W-1:0];
			end
		end
		mx = dx[0];
		if (dx[1] > mx) begin
			mx = dx[1];
		end
		if (dx[2] > mx) begin
			mx = dx[2];
		end
		mx_half = mx >>> 1;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
		end else begin
			if (rdy1) v_s1 <= in_valid;
			if (rdy2) v_s2 <= v_s1;
			if (rdy3) v_s3 <= v_s2;
			if (rdy4) v_s4 <= v_s3;
			if (rdy5) v_s5 <= v_s4;
		end
	end

	always_ff @(posedge clk) begin
		if (rdy1) begin
			t_s1 <= t_nx;
		end
		if (rdy2) begin
			d_s2 <= d_nx;
		end
		if (rdy3) begin
			u_s3      <= u_nx;
			inside_s3 <= (mx < 0);
			half_s3   <= mx_half[bsd_pkg::OUT_W-1:0];
		end
		if (rdy4) begin
			for (int a = 0; a < 3; a++) begin
				sq_s4[a] <= u_s3[a] * u_s3[a];
			end
			inside_s4 <= inside_s3;
			half_s4   <= half_s3;
		end
		if (rdy5) begin
			sum_s5    <= sq_s4[0] + sq_s4[1] + sq_s4[2];
			inside_s5 <= inside_s4;
			half_s5   <= half_s4;
		end
	end

	assign out_valid       = v_s5;
	assign out_word.rad    = sum_s5;
	assign out_word.rem    = '0;
	assign out_word.root   = '0;
	assign out_word.in_box = inside_s5;
	assign out_word.half   = half_s5;

endmodule

// File: rtl/bsd_sqrt_cell.sv
// ----------------------------------------------------------------------------
// bsd_sqrt_cell: one digit of the integer square root
// Takes two radicand bits, settles one root bit, registers the word.
// ----------------------------------------------------------------------------
module bsd_sqrt_cell (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_ready,
	input  bsd_pkg::sqrt_word_t in_word,
	output logic                out_valid,
	input  logic                out_ready,
	output bsd_pkg::sqrt_word_t out_word
);

	logic                valid_q;
	bsd_pkg::sqrt_word_t word_q;
	bsd_pkg::sqrt_word_t word_nx;

	logic [bsd_pkg::REM_W-1:0] rem_sh;
	logic [bsd_pkg::REM_W-1:0] trial;
	logic                      take;

	// remainder before this digit stays below 2^(ROOT_W), so the shift keeps it
	assign rem_sh = {in_word.rem[bsd_pkg::REM_W-3:0],
		in_word.rad[bsd_pkg::SUM_W-1 -: 2]};
	assign trial  = {in_word.root, 2'b01};
	assign take   = (rem_sh >= trial);

	always_comb begin
		word_nx      = in_word;
		word_nx.rad  = {in_word.rad[bsd_pkg::SUM_W-3:0], 2'b00};
		word_nx.rem  = take ? (rem_sh - trial) : rem_sh;
		word_nx.root = {in_word.root[bsd_pkg::ROOT_W-2:0], take};
	end

	assign in_ready = !valid_q || out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (in_ready) begin
			valid_q <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready) begin
			word_q <= word_nx;
		end
	end

	assign out_valid = valid_q;
	assign out_word  = word_q;

endmodule

// File: rtl/box_signed_distance.sv
// ----------------------------------------------------------------------------
// box_signed_distance: signed distance from a point to the centered cube
// Offsets per axis in doubled units, squares, then a chain of root cells.
// ----------------------------------------------------------------------------
//
//  channel  | signals                               | direction
//  ---------+---------------------------------------+----------
//  point    | point_valid/ready, point_x/y/z        | in
//  distance | dist_valid/ready, signed_distance     | out
//  config   | cfg_we, cfg_index, cfg_wdata          | in, write only
//
//  One word per cycle sustained while dist_ready holds; 5 front stages, 27 root
//  cells, one output register. The depth is set mostly by the root chain: one
//  cell per root bit of the 54-bit sum of squares.
//  Reset clears valid bits and config registers; payload is not reset.
//  Every stage has its own valid, so a stalled output only fills bubbles
//  behind it; point_ready drops once the whole chain is full.
//
//  Math: d = |2p - scene| - cube (twice the usual q).
//  Outside: floor(isqrt(sum of max(d,0)^2) / 2), saturated to 2^25-1.
//  Inside:  floor(max(d) / 2), negative.
// ----------------------------------------------------------------------------
module box_signed_distance #(
	parameter int COORD_WIDTH = 24
) (
	input  logic                              clk,
	input  logic                              arst_n,
	// configuration
	input  logic                              cfg_we,
	input  logic [bsd_pkg::CFG_IDX_W-1:0]     cfg_index,
	input  logic [bsd_pkg::CFG_W-1:0]         cfg_wdata,
	// query point
	input  logic                              point_valid,
	output logic                              point_ready,
	input  logic signed [COORD_WIDTH-1:0]     point_x,
	input  logic signed [COORD_WIDTH-1:0]     point_y,
	input  logic signed [COORD_WIDTH-1:0]     point_z,
	// result
	output logic                              dist_valid,
	input  logic                              dist_ready,
	output logic signed [bsd_pkg::OUT_W-1:0]  signed_distance
);

	localparam int NCELL = bsd_pkg::ROOT_W;

	// config registers
	logic [2:0][bsd_pkg::CFG_W-1:0] scene_q;
	logic [bsd_pkg::CFG_W-1:0]      cube_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			scene_q <= '0;
			cube_q  <= '0;
		end else if (cfg_we) begin
			unique case (cfg_index)
				bsd_pkg::REG_SCENE_X: scene_q[0] <= cfg_wdata;
				bsd_pkg::REG_SCENE_Y: scene_q[1] <= cfg_wdata;
				bsd_pkg::REG_SCENE_Z: scene_q[2] <= cfg_wdata;
				bsd_pkg::REG_CUBE:    cube_q     <= cfg_wdata;
			endcase
		end
	end

	// root chain links: link 0 is the front output, link NCELL the last cell
	logic                cv [NCELL+1];
	logic                cr [NCELL+1];
	bsd_pkg::sqrt_word_t cw [NCELL+1];

	bsd_front #(
		.COORD_WIDTH(COORD_WIDTH)
	) u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (point_valid),
		.in_ready (point_ready),
		.point_x  (point_x),
		.point_y  (point_y),
		.point_z  (point_z),
		.scene    (scene_q),
		.cube     (cube_q),
		.out_valid(cv[0]),
		.out_ready(cr[0]),
		.out_word (cw[0])
	);

	for (genvar i = 0; i < NCELL; i++) begin : g_cell
		bsd_sqrt_cell u_cell (
			.clk      (clk),
			.arst_n   (arst_n),
			.in_valid (cv[i]),
			.in_ready (cr[i]),
			.in_word  (cw[i]),
			.out_valid(cv[i+1]),
			.out_ready(cr[i+1]),
			.out_word (cw[i+1])
		);
	end

	// output register: pick inside or halved outside distance
	logic                       out_valid_q;
	logic [bsd_pkg::OUT_W-1:0]  dist_q;
	logic [bsd_pkg::OUT_W-1:0]  dist_nx;
	logic                       out_load;

	assign out_load     = !out_valid_q || dist_ready;
	assign cr[NCELL]    = out_load;

	always_comb begin
		if (cw[NCELL].in_box) begin
			dist_nx = cw[NCELL].half;
		end else if (cw[NCELL].root[bsd_pkg::ROOT_W-1]) begin
			dist_nx = bsd_pkg::OUT_MAX;   // root/2 above the output range
		end else begin
			dist_nx = {1'b0, cw[NCELL].root[bsd_pkg::ROOT_W-2:1]};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_load) begin
			out_valid_q <= cv[NCELL];
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			dist_q <= dist_nx;
		end
	end

	assign dist_valid      = out_valid_q;
	assign signed_distance = $signed(dist_q);

endmodule
